/* rtl/core/lphs_pkg.sv */
// shared types and constants of the linear probe hash set
package lphs_pkg;

    localparam int unsigned CMD_W = 2;
    localparam int unsigned KEY_W = 32;
    localparam int unsigned SLOT_W = 4;
    localparam int unsigned FLAG_W = 2;
    localparam int unsigned ENTRY_W = FLAG_W + KEY_W;
    localparam int unsigned IN_TDATA_W = 40;
    localparam int unsigned OUT_TDATA_W = 8;
    localparam int unsigned TABLE_SLOTS_DEF = 16;
    localparam int unsigned MOD_BITS = 4;
    localparam int unsigned MOD_STEPS = KEY_W / MOD_BITS;
    localparam int unsigned MOD_CNT_W = $clog2(MOD_STEPS + 1);

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MEMBER = 2'd2;

    localparam logic [FLAG_W-1:0] FLAG_EMPTY = 2'd0;
    localparam logic [FLAG_W-1:0] FLAG_TAKEN = 2'd1;
    localparam logic [FLAG_W-1:0] FLAG_DELETED = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic clr_wr;
        logic scan_load;
        logic scan_step;
        logic wr_en;
        logic res_load;
        logic res_ok;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             hash_done;
        logic             probe_last;
        logic             step_first;
        logic             step_last;
        logic             hit;
        logic             home_empty;
    } dp_stat_t;

endpackage

/* rtl/core/lphs_ram.sv */
// generic single write port ram with registered read
module lphs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/lphs_mod.sv */
// home slot unit: key modulo table size, by a mask for a power of two, else MOD_BITS key bits per step
module lphs_mod
    import lphs_pkg::*;
#(
    parameter int unsigned TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [KEY_W-1:0]               key,
    output logic                           done,
    output logic [$clog2(TABLE_SLOTS)-1:0] home
);

    localparam int unsigned IDX_W = $clog2(TABLE_SLOTS);
    localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

    generate
        if (IS_POW2)
        begin : g_mask
            logic [IDX_W-1:0] home_reg;

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    home_reg <= key[IDX_W-1:0];
                end
            end

            assign home = home_reg;
            assign done = 1'b1;
        end
        else
        begin : g_iter
            localparam logic [IDX_W:0] MODULUS = (IDX_W + 1)'(TABLE_SLOTS);
            localparam logic [MOD_CNT_W-1:0] CNT_DONE = MOD_CNT_W'(MOD_STEPS);

            logic [IDX_W-1:0]     rem_reg;
            logic [IDX_W-1:0]     rem_next;
            logic [KEY_W-1:0]     sh_reg;
            logic [MOD_CNT_W-1:0] cnt_reg;
            logic [IDX_W:0]       t;

            // restoring remainder, one key bit per sub-step
            always_comb
            begin
                rem_next = rem_reg;
                t = '0;
                for (int i = 0; i < MOD_BITS; i++)
                begin
                    t = {rem_next, sh_reg[KEY_W-1-i]};
                    if (t >= MODULUS)
                    begin
                        t = t - MODULUS;
                    end
                    rem_next = t[IDX_W-1:0];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    cnt_reg <= CNT_DONE;
                end
                else if (start)
                begin
                    cnt_reg <= '0;
                end
                else if (cnt_reg != CNT_DONE)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg <= '0;
                    sh_reg <= key;
                end
                else if (cnt_reg != CNT_DONE)
                begin
                    rem_reg <= rem_next;
                    sh_reg <= sh_reg << MOD_BITS;
                end
            end

            assign home = rem_reg;
            assign done = (cnt_reg == CNT_DONE);
        end
    endgenerate

endmodule

/* rtl/core/lphs_dp.sv */
// datapath: table memory, probe pointer, hit logic and result registers
module lphs_dp
    import lphs_pkg::*;
#(
    parameter int unsigned TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dp_cmd_t                cmd,
    output dp_stat_t               stat,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int unsigned IDX_W = $clog2(TABLE_SLOTS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SLOTS - 1);

    logic [CMD_W-1:0]   op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [IDX_W-1:0]   probe_reg;
    logic [IDX_W-1:0]   probe_next;
    logic [IDX_W-1:0]   probe_inc;
    logic [IDX_W-1:0]   step_reg;
    logic [IDX_W-1:0]   home;
    logic               hash_done;
    logic               ram_wr_en;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic [ENTRY_W-1:0] rd_data;
    logic [FLAG_W-1:0]  rd_flag;
    logic [KEY_W-1:0]   rd_key;
    logic               res_ok_reg;
    logic [SLOT_W-1:0]  res_slot_reg;
    logic               out_ok_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic [SLOT_W+IDX_W-1:0] slot_wide;

    lphs_mod #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_mod (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cmd.accept),
        .key  (s_tdata[CMD_W +: KEY_W]),
        .done (hash_done),
        .home (home)
    );

    assign probe_inc = (probe_reg == IDX_LAST) ? '0 : probe_reg + 1'b1;

    // read address runs one step ahead so read data matches probe_reg
    always_comb
    begin
        if (cmd.scan_load)
        begin
            probe_next = home;
        end
        else if (cmd.scan_step || cmd.clr_wr)
        begin
            probe_next = probe_inc;
        end
        else
        begin
            probe_next = probe_reg;
        end
    end

    assign rd_flag = rd_data[KEY_W +: FLAG_W];
    assign rd_key = rd_data[KEY_W-1:0];

    always_comb
    begin
        ram_wr_en = cmd.clr_wr || cmd.wr_en;
        if (cmd.clr_wr)
        begin
            ram_wr_data = {FLAG_EMPTY, {KEY_W{1'b0}}};
        end
        else if (op_reg == CMD_INSERT)
        begin
            ram_wr_data = {FLAG_TAKEN, key_reg};
        end
        else
        begin
            ram_wr_data = {FLAG_DELETED, rd_key};
        end
    end

    lphs_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_SLOTS)
    ) u_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(probe_reg),
        .wr_data(ram_wr_data),
        .rd_addr(probe_next),
        .rd_data(rd_data)
    );

    always_comb
    begin
        stat.cmd = op_reg;
        stat.hash_done = hash_done;
        stat.probe_last = (probe_reg == IDX_LAST);
        stat.step_first = (step_reg == '0);
        stat.step_last = (step_reg == IDX_LAST);
        stat.home_empty = (rd_flag == FLAG_EMPTY);
        case (op_reg)
            CMD_INSERT:
            begin
                stat.hit = (rd_flag == FLAG_EMPTY) || (rd_flag == FLAG_DELETED);
            end
            CMD_DELETE, CMD_MEMBER:
            begin
                stat.hit = (rd_flag == FLAG_TAKEN) && (rd_key == key_reg);
            end
            default:
            begin
                stat.hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
            step_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
            if (cmd.scan_load)
            begin
                step_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    assign slot_wide = {{SLOT_W{1'b0}}, probe_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg <= s_tdata[CMD_W-1:0];
            key_reg <= s_tdata[CMD_W +: KEY_W];
        end
        if (cmd.res_load)
        begin
            res_ok_reg <= cmd.res_ok;
            res_slot_reg <= cmd.res_ok ? slot_wide[SLOT_W-1:0] : '0;
        end
        if (cmd.out_load)
        begin
            out_ok_reg <= res_ok_reg;
            out_slot_reg <= res_slot_reg;
        end
    end

    assign m_tdata = {{(OUT_TDATA_W - SLOT_W - 1){1'b0}}, out_slot_reg, out_ok_reg};

endmodule

/* rtl/core/lphs_ctrl.sv */
// controller: clearing pass, hashing, probe sequencing and output handshake
module lphs_ctrl
    import lphs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        s_tready = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.probe_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (stat.hash_done)
                begin
                    if (stat.cmd == CMD_INSERT || stat.cmd == CMD_DELETE ||
                        stat.cmd == CMD_MEMBER)
                    begin
                        cmd.scan_load = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.res_load = 1'b1;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (stat.cmd == CMD_MEMBER && stat.step_first && stat.home_empty)
                begin
                    cmd.res_load = 1'b1;
                    state_next = ST_DONE;
                end
                else if (stat.hit)
                begin
                    cmd.wr_en = (stat.cmd != CMD_MEMBER);
                    cmd.res_load = 1'b1;
                    cmd.res_ok = 1'b1;
                    state_next = ST_DONE;
                end
                else if (stat.step_last)
                begin
                    cmd.res_load = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

/* rtl/core/linear_probe_hash_set.sv */
// top level of the linear probe hash set
// Open-addressed set of 32-bit keys with linear probing and tombstones. After
// reset the block runs a clearing pass over every table slot before it takes
// its first item. Each item then passes the home slot computation (a mask when
// TABLE_SLOTS is a power of two, else a 4-bit-per-cycle remainder unit) and a
// probe of 1 to TABLE_SLOTS slots (none for the unused command), one table
// memory read per cycle, before its result is offered. The next item is taken
// only once that result has moved to the output register, which waits while an
// earlier result there is not yet taken. A new item is taken while the previous
// result still waits in the output register.
module linear_probe_hash_set
    import lphs_pkg::*;
#(
    parameter int unsigned TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // command[1:0], key[33:2], zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata   // ok[0], slot[4:1], zero pad
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lphs_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lphs_dp #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .s_tdata(s_tdata),
        .m_tdata(m_tdata)
    );

endmodule
